### src/srrw_pkg.sv
package srrw_pkg;

    localparam int WINDOW_MAX = 32;
    localparam int SLOT_W     = $clog2(WINDOW_MAX);
    localparam int WIN_W      = 6;
    localparam int ID_W       = 32;
    localparam int LEN_W      = 11;
    localparam int BYTES_W    = 32;
    localparam int CFG_W      = 31;

    localparam logic [WIN_W-1:0] WINDOW_MIN   = WIN_W'(10);
    localparam logic [WIN_W-1:0] WINDOW_LIMIT = WIN_W'(WINDOW_MAX);
    localparam logic [LEN_W-1:0] MAX_LOAD     = LEN_W'(1394);

    // Result kinds.
    localparam logic [1:0] KIND_ACK     = 2'd0;
    localparam logic [1:0] KIND_NAK     = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;
    localparam logic [1:0] KIND_IGNORED = 2'd3;

    // Configuration register indexes.
    localparam logic REG_WINDOW_SIZE = 1'b0;
    localparam logic REG_FILE_BYTES  = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]  packet_id;
        logic [LEN_W-1:0] packet_length;
        logic             crc_good;
    } t_item;

    typedef struct packed {
        logic [1:0]        result_kind;
        logic [ID_W-1:0]   ack_id;
        logic [SLOT_W-1:0] slot_index;
        logic [LEN_W-1:0]  release_length;
        logic              transfer_done;
        logic              last_of_run;
    } t_result;

    // The byte count is spent once it is zero or negative as a signed value.
    function automatic logic count_exhausted(input logic [BYTES_W-1:0] count);
        return (count == '0) || count[BYTES_W-1];
    endfunction

    function automatic logic [WIN_W-1:0] eff_window(input logic [WIN_W-1:0] size);
        logic [WIN_W-1:0] w;
        w = size;
        if (w < WINDOW_MIN) begin
            w = WINDOW_MIN;
        end
        if (w > WINDOW_LIMIT) begin
            w = WINDOW_LIMIT;
        end
        return w;
    endfunction

endpackage

### src/srrw_rem.sv
// Restoring remainder unit: one dividend bit per cycle.
module srrw_rem (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [srrw_pkg::ID_W-1:0]         i_dividend,
    input  logic [srrw_pkg::WIN_W-1:0]        i_divisor,
    output logic                              o_done,
    output logic [srrw_pkg::SLOT_W-1:0]       o_rem
);

    localparam int CNT_W = $clog2(srrw_pkg::ID_W);

    logic                          r_busy;
    logic                          r_done;
    logic [CNT_W-1:0]              r_cnt;
    logic [srrw_pkg::ID_W-1:0]     r_dvd;
    logic [srrw_pkg::WIN_W-1:0]    r_div;
    logic [srrw_pkg::SLOT_W-1:0]   r_rem;

    logic [srrw_pkg::SLOT_W:0]     trial;
    logic [srrw_pkg::SLOT_W:0]     diff;
    logic [srrw_pkg::SLOT_W-1:0]   n_rem;

    // The partial remainder stays below the divisor, so the shifted value fits
    // one bit more than a slot index and the difference fits a slot index.
    always_comb begin
        trial = {r_rem, r_dvd[srrw_pkg::ID_W-1]};
        diff  = trial - (srrw_pkg::SLOT_W+1)'(r_div);
        if ((srrw_pkg::SLOT_W+1)'(r_div) <= trial) begin
            n_rem = diff[srrw_pkg::SLOT_W-1:0];
        end else begin
            n_rem = trial[srrw_pkg::SLOT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_dvd  <= i_dividend;
                r_div  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_dvd <= {r_dvd[srrw_pkg::ID_W-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(srrw_pkg::ID_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

### src/selective_repeat_receive_window.sv
// Receive window of a selective-repeat link. Each item describes one received
// packet and is taken when start is high and busy is low. A packet with a bad
// checksum or an id outside the window is answered with one NAK in the cycle
// after it is taken, and once the expected byte count is used up every item is
// answered with one ignored result; both leave busy low, so such items can
// follow each other in every cycle. A good in-window packet is answered with an
// ACK and then one release result per in-order slot that becomes free. Its
// slot is id modulo the window, found by a bit-serial remainder unit that takes
// one id bit per cycle, and busy stays high while the remainder is found and
// while slots are released, at most a full window of them per item. Slot
// lengths live in a small synchronous memory read one slot ahead, so the flush
// releases one slot per cycle. Results appear for exactly one cycle, marked
// by o_result_valid, and the receiver cannot stall them. Configuration must be
// written only while the block is idle, which the block itself does not
// enforce; writing file_bytes also reloads the remaining byte count.
module selective_repeat_receive_window (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  srrw_pkg::t_item             i_item,
    output logic                        o_result_valid,
    output srrw_pkg::t_result           o_result,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [srrw_pkg::CFG_W-1:0]  i_cfg_data
);

    localparam int SLOT_W  = srrw_pkg::SLOT_W;
    localparam int WIN_W   = srrw_pkg::WIN_W;
    localparam int ID_W    = srrw_pkg::ID_W;
    localparam int LEN_W   = srrw_pkg::LEN_W;
    localparam int BYTES_W = srrw_pkg::BYTES_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MODW,
        S_FLUSH
    } t_state;

    t_state                          r_state, n_state;
    logic [WIN_W-1:0]                r_window_size, n_window_size;
    logic [ID_W-1:0]                 r_expected, n_expected;
    logic [SLOT_W-1:0]               r_head, n_head;
    logic [BYTES_W-1:0]              r_remaining, n_remaining;
    logic [srrw_pkg::WINDOW_MAX-1:0] r_full, n_full;
    logic                            r_done, n_done;
    logic [ID_W-1:0]                 r_id, n_id;
    logic [LEN_W-1:0]                r_len, n_len;
    logic [WIN_W-1:0]                r_cnt, n_cnt;
    logic                            r_out_valid, n_out_valid;
    srrw_pkg::t_result               r_out, n_out;

    // Slot length store: one write port, one registered read port.
    logic [LEN_W-1:0]                r_len_mem [srrw_pkg::WINDOW_MAX];
    logic [LEN_W-1:0]                r_rd_data;
    logic                            wr_en;
    logic [SLOT_W-1:0]               wr_addr;

    logic [WIN_W-1:0]                win;
    logic [ID_W-1:0]                 offset;
    logic                            rem_start;
    logic                            rem_done;
    logic [SLOT_W-1:0]               rem_value;
    logic [SLOT_W-1:0]               head_next;
    logic [BYTES_W-1:0]              left_after;
    logic                            more;

    srrw_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (i_item.packet_id),
        .i_divisor  (win),
        .o_done     (rem_done),
        .o_rem      (rem_value)
    );

    function automatic srrw_pkg::t_result make_result(
        input logic [1:0]        kind,
        input logic [ID_W-1:0]   id,
        input logic [SLOT_W-1:0] slot,
        input logic [LEN_W-1:0]  len,
        input logic              done,
        input logic              last
    );
        srrw_pkg::t_result res;
        res.result_kind    = kind;
        res.ack_id         = id;
        res.slot_index     = slot;
        res.release_length = len;
        res.transfer_done  = done;
        res.last_of_run    = last;
        return res;
    endfunction

    always_comb begin
        win    = srrw_pkg::eff_window(r_window_size);
        offset = i_item.packet_id - r_expected;

        // The head wraps to zero once it reaches the last slot of the window,
        // also when a smaller window was set while the head was beyond it.
        if (WIN_W'(r_head) >= win - 1'b1) begin
            head_next = '0;
        end else begin
            head_next = r_head + 1'b1;
        end
        left_after = r_remaining - BYTES_W'(r_rd_data);

        n_state       = r_state;
        n_window_size = r_window_size;
        n_expected    = r_expected;
        n_head        = r_head;
        n_remaining   = r_remaining;
        n_full        = r_full;
        n_done        = r_done;
        n_id          = r_id;
        n_len         = r_len;
        n_cnt         = r_cnt;
        n_out_valid   = 1'b0;
        n_out         = r_out;
        rem_start     = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = rem_value;
        more          = 1'b0;

        if (i_cfg_we) begin
            case (i_cfg_index)
                srrw_pkg::REG_WINDOW_SIZE: n_window_size = i_cfg_data[WIN_W-1:0];
                srrw_pkg::REG_FILE_BYTES:  n_remaining   = {1'b0, i_cfg_data};
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (r_done || srrw_pkg::count_exhausted(r_remaining)) begin
                        n_done      = 1'b1;
                        n_out_valid = 1'b1;
                        n_out       = make_result(srrw_pkg::KIND_IGNORED, '0, '0, '0,
                                                  1'b1, 1'b1);
                    end else if (!i_item.crc_good || offset >= ID_W'(win)) begin
                        n_out_valid = 1'b1;
                        n_out       = make_result(srrw_pkg::KIND_NAK, '0, '0, '0,
                                                  1'b0, 1'b1);
                    end else begin
                        n_id      = i_item.packet_id;
                        n_len     = (i_item.packet_length > srrw_pkg::MAX_LOAD) ?
                                    srrw_pkg::MAX_LOAD : i_item.packet_length;
                        rem_start = 1'b1;
                        n_state   = S_MODW;
                    end
                end
            end
            S_MODW: begin
                if (rem_done) begin
                    // Store the length, then see whether the head slot is now
                    // filled; the read of the head slot is forwarded if it is
                    // the slot just written.
                    wr_en             = 1'b1;
                    n_full[rem_value] = 1'b1;
                    more              = r_full[r_head] || (rem_value == r_head);
                    n_cnt             = '0;
                    n_out_valid       = 1'b1;
                    n_out             = make_result(srrw_pkg::KIND_ACK, r_id, '0, '0,
                                                    1'b0, !more);
                    n_state           = more ? S_FLUSH : S_IDLE;
                end
            end
            S_FLUSH: begin
                // r_rd_data holds the length of the head slot, which is full.
                n_full[r_head] = 1'b0;
                n_remaining    = left_after;
                n_expected     = r_expected + 1'b1;
                n_head         = head_next;
                n_cnt          = r_cnt + 1'b1;
                if (srrw_pkg::count_exhausted(left_after)) begin
                    n_done = 1'b1;
                end
                more           = r_full[head_next] && (n_cnt != win);
                n_out_valid    = 1'b1;
                n_out          = make_result(srrw_pkg::KIND_RELEASE, '0, r_head, r_rd_data,
                                             srrw_pkg::count_exhausted(left_after), !more);
                n_state        = more ? S_FLUSH : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_window_size <= srrw_pkg::WINDOW_MIN;
            r_expected    <= '0;
            r_head        <= '0;
            r_remaining   <= '0;
            r_full        <= '0;
            r_done        <= 1'b0;
            r_cnt         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_window_size <= n_window_size;
            r_expected    <= n_expected;
            r_head        <= n_head;
            r_remaining   <= n_remaining;
            r_full        <= n_full;
            r_done        <= n_done;
            r_cnt         <= n_cnt;
            r_out_valid   <= n_out_valid;
            r_id          <= n_id;
            r_len         <= n_len;
            r_out         <= n_out;
        end
    end

    // The read always targets the next head, so the data for a slot is ready
    // in the cycle it is released. A write to the same slot is forwarded.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_len_mem[wr_addr] <= r_len;
        end
        if (wr_en && (wr_addr == n_head)) begin
            r_rd_data <= r_len;
        end else begin
            r_rd_data <= r_len_mem[n_head];
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

    // A release is only shown right after a flush cycle.
    a_release_from_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_result.result_kind == srrw_pkg::KIND_RELEASE))
        |-> $past(r_state == S_FLUSH))
        else $error("release result without a flush cycle");

    // Every flush cycle works on a filled head slot.
    a_flush_head_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH) |-> r_full[r_head])
        else $error("flush on an empty head slot");

    // The remainder unit only finishes while its result is awaited.
    a_rem_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rem_done |-> (r_state == S_MODW))
        else $error("remainder finished outside the wait state");

    // Once the transfer is done it stays done until reset.
    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> r_done)
        else $error("done flag cleared");

endmodule
